// ----- rtl/lrt_pkg.sv -----
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants of the linkable reload timer
// Command codes, control register bit positions and the result record.
// ----------------------------------------------------------------------------
package lrt_pkg;

    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_WR_BACKUP  = 4'd1,
        CMD_WR_CTRLA   = 4'd2,
        CMD_WR_COUNT   = 4'd3,
        CMD_WR_CTRLB   = 4'd4,
        CMD_RD_BACKUP  = 4'd5,
        CMD_RD_CTRLA   = 4'd6,
        CMD_RD_COUNT   = 4'd7,
        CMD_RD_CTRLB   = 4'd8,
        CMD_BORROW_IN  = 4'd9
    } cmd_t;

    localparam int CMD_W  = 4;
    localparam int DATA_W = 8;
    localparam int TDATA_W = 16;

    // ctrlA bit positions
    localparam int CA_INT_EN    = 7;
    localparam int CA_RESET_DONE = 6;
    localparam int CA_RELOAD_EN = 4;
    localparam int CA_COUNT_EN  = 3;

    // ctrlB bit positions
    localparam int CB_DONE       = 3;
    localparam int CB_LAST_TICK  = 2;
    localparam int CB_BORROW_IN  = 1;
    localparam int CB_BORROW_OUT = 0;

    localparam logic [2:0] CLK_SEL_LINKED = 3'd7;

    typedef struct packed {
        logic              irq;
        logic              fire;
        logic [DATA_W-1:0] read_data;
    } res_t;

endpackage

// ----- rtl/lrt_timer.sv -----
// ----------------------------------------------------------------------------
// lrt_timer: timer state and per-beat update
// Holds the timer registers and computes the result of one command beat.
// ----------------------------------------------------------------------------
module lrt_timer
    import lrt_pkg::*;
#(
    parameter int PRESCALE_BASE = 16,
    parameter int BORROW_WINDOW = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  cmd_t              cmd,
    input  logic [DATA_W-1:0] wdata,
    output res_t              res
);

    localparam int PRE_W = $clog2(PRESCALE_BASE * 128);
    localparam int AGE_W = $clog2(BORROW_WINDOW + 1);
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(BORROW_WINDOW);

    logic [DATA_W-1:0] backup_reg, backup_next;
    logic [DATA_W-1:0] count_reg, count_next;
    logic [PRE_W-1:0]  pre_reg, pre_next;
    logic              running_reg, running_next;
    logic              int_en_reg, int_en_next;
    logic              rst_done_reg, rst_done_next;
    logic              reload_reg, reload_next;
    logic              count_en_reg, count_en_next;
    logic [2:0]        clk_sel_reg, clk_sel_next;
    logic              done_reg, done_next;
    logic              last_clk_reg, last_clk_next;
    logic [AGE_W-1:0]  bin_age_reg, bin_age_next;
    logic [AGE_W-1:0]  bout_age_reg, bout_age_next;

    logic              do_restart;
    logic              fired;
    logic [DATA_W-1:0] rd;
    logic [PRE_W-1:0]  period_cur;
    logic [PRE_W-1:0]  period_new;

    assign period_cur = (PRE_W'(PRESCALE_BASE) << clk_sel_reg) - PRE_W'(1);
    assign period_new = (PRE_W'(PRESCALE_BASE) << clk_sel_next) - PRE_W'(1);

    always_comb begin
        backup_next   = backup_reg;
        count_next    = count_reg;
        pre_next      = pre_reg;
        running_next  = running_reg;
        int_en_next   = int_en_reg;
        rst_done_next = rst_done_reg;
        reload_next   = reload_reg;
        count_en_next = count_en_reg;
        clk_sel_next  = clk_sel_reg;
        done_next     = done_reg;
        last_clk_next = last_clk_reg;
        bin_age_next  = bin_age_reg;
        bout_age_next = bout_age_reg;
        do_restart    = 1'b0;
        fired         = 1'b0;
        rd            = '0;

        unique case (cmd)
            CMD_TICK: begin
                if (bin_age_reg < AGE_MAX) bin_age_next = bin_age_reg + AGE_W'(1);
                if (bout_age_reg < AGE_MAX) bout_age_next = bout_age_reg + AGE_W'(1);
                if (running_reg) begin
                    if (pre_reg == '0) begin
                        pre_next = period_cur;
                        if (count_reg == '0) begin
                            fired         = 1'b1;
                            done_next     = 1'b1;
                            bout_age_next = '0;
                            do_restart    = 1'b1;
                        end else begin
                            count_next = count_reg - DATA_W'(1);
                        end
                    end else begin
                        pre_next = pre_reg - PRE_W'(1);
                    end
                end
            end
            CMD_WR_BACKUP: begin
                backup_next = wdata;
                count_next  = '0;
                do_restart  = 1'b1;
            end
            CMD_WR_CTRLA: begin
                int_en_next   = wdata[CA_INT_EN];
                rst_done_next = wdata[CA_RESET_DONE];
                reload_next   = wdata[CA_RELOAD_EN];
                count_en_next = wdata[CA_COUNT_EN];
                clk_sel_next  = wdata[2:0];
                if (wdata[CA_RESET_DONE]) done_next = 1'b0;
                do_restart    = 1'b1;
            end
            CMD_WR_COUNT: begin
                count_next = wdata;
                do_restart = 1'b1;
            end
            CMD_WR_CTRLB: begin
                done_next     = wdata[CB_DONE];
                last_clk_next = wdata[CB_LAST_TICK];
                do_restart    = 1'b1;
            end
            CMD_RD_BACKUP: rd = backup_reg;
            CMD_RD_CTRLA: begin
                rd[CA_INT_EN]     = int_en_reg;
                rd[CA_RESET_DONE] = rst_done_reg;
                rd[CA_RELOAD_EN]  = reload_reg;
                rd[CA_COUNT_EN]   = count_en_reg;
                rd[2:0]           = clk_sel_reg;
            end
            CMD_RD_COUNT: rd = count_reg;
            CMD_RD_CTRLB: begin
                last_clk_next     = (count_reg == '0);
                rd[CB_DONE]       = done_reg;
                rd[CB_LAST_TICK]  = (count_reg == '0);
                rd[CB_BORROW_IN]  = (bin_age_reg < AGE_MAX);
                rd[CB_BORROW_OUT] = (bout_age_reg < AGE_MAX);
            end
            CMD_BORROW_IN: begin
                bin_age_next = '0;
                if (count_en_reg && clk_sel_reg == CLK_SEL_LINKED
                        && !(done_reg && !reload_reg)) begin
                    if (count_reg != '0) begin
                        count_next    = count_reg - DATA_W'(1);
                        last_clk_next = (count_reg == DATA_W'(1));
                    end else begin
                        if (last_clk_reg) begin
                            last_clk_next = 1'b0;
                            done_next     = 1'b1;
                            fired         = 1'b1;
                            bout_age_next = '0;
                        end
                        if (reload_reg) count_next = backup_reg;
                    end
                end
            end
            default: ;
        endcase

        if (do_restart) begin
            running_next = 1'b0;
            if (count_en_next && clk_sel_next != CLK_SEL_LINKED
                    && !(done_next && !reload_next)) begin
                if (count_next == '0 || reload_next) count_next = backup_next;
                if (count_next != '0) begin
                    running_next = 1'b1;
                    pre_next     = period_new;
                end
            end
        end
    end

    assign res.read_data = rd;
    assign res.fire      = fired;
    assign res.irq       = fired && int_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backup_reg   <= '0;
            count_reg    <= '0;
            pre_reg      <= '0;
            running_reg  <= 1'b0;
            int_en_reg   <= 1'b0;
            rst_done_reg <= 1'b0;
            reload_reg   <= 1'b0;
            count_en_reg <= 1'b0;
            clk_sel_reg  <= '0;
            done_reg     <= 1'b0;
            last_clk_reg <= 1'b0;
            bin_age_reg  <= AGE_MAX;
            bout_age_reg <= AGE_MAX;
        end else if (step) begin
            backup_reg   <= backup_next;
            count_reg    <= count_next;
            pre_reg      <= pre_next;
            running_reg  <= running_next;
            int_en_reg   <= int_en_next;
            rst_done_reg <= rst_done_next;
            reload_reg   <= reload_next;
            count_en_reg <= count_en_next;
            clk_sel_reg  <= clk_sel_next;
            done_reg     <= done_next;
            last_clk_reg <= last_clk_next;
            bin_age_reg  <= bin_age_next;
            bout_age_reg <= bout_age_next;
        end
    end

endmodule

// ----- rtl/linkable_reload_timer_unit.sv -----
// ----------------------------------------------------------------------------
// linkable_reload_timer_unit: 8-bit linkable reload timer with prescaler
// One command beat in, one result beat out, with registered input and output.
// ----------------------------------------------------------------------------
// Each input beat is one command: a tick of the system clock, a register write
// or read, or a borrow in from a linked timer. The unit takes one beat per
// clock cycle while the output is not stalled. A beat sits in the input
// register while the timer update runs; its result is registered into the
// output register when the beat advances and is offered on the result port.
// Throughout, the combinational timer update closes the loop from one beat to
// the next. The input side keeps accepting while a result waits on the output
// side, and stalls only when both registers are full.
module linkable_reload_timer_unit
    import lrt_pkg::*;
#(
    parameter int PRESCALE_BASE = 16,
    parameter int BORROW_WINDOW = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // [3:0] cmd, [11:4] wdata
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata   // [7:0] read_data, [8] fire, [9] irq
);

    logic              in_valid_reg;
    logic [CMD_W-1:0]  in_cmd_reg;
    logic [DATA_W-1:0] in_wdata_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    res_t              res;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tdata[CMD_W-1:0];
            in_wdata_reg <= s_tdata[CMD_W+DATA_W-1:CMD_W];
        end
        if (advance) out_res_reg <= res;
    end

    lrt_timer #(
        .PRESCALE_BASE(PRESCALE_BASE),
        .BORROW_WINDOW(BORROW_WINDOW)
    ) u_timer (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (advance),
        .cmd    (cmd_t'(in_cmd_reg)),
        .wdata  (in_wdata_reg),
        .res    (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W-DATA_W-2)'(0), out_res_reg.irq, out_res_reg.fire,
                       out_res_reg.read_data};

endmodule

// ----- rtl/lrt_checker.sv -----
// ----------------------------------------------------------------------------
// lrt_checker: port-level checks of the linkable reload timer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module lrt_checker
    import lrt_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_irq_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[8])
        else $error("irq without fire");

    a_fire_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("fire on a read beat");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TDATA_W-1:10] == '0)
        else $error("nonzero padding in result beat");

endmodule

bind linkable_reload_timer_unit lrt_checker u_lrt_checker (.*);
